### hdl/position_stats_table_defines.svh
// Assertion helpers for the position statistics table.
`ifndef POSITION_STATS_TABLE_DEFINES_SVH
`define POSITION_STATS_TABLE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PST_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PST_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

### hdl/pst_pkg.sv
`default_nettype none
package pst_pkg;
   localparam int Capacity = 32;
   localparam int IdxW = $clog2(Capacity);
   localparam int FillW = $clog2(Capacity + 1);

   typedef enum logic [1:0] {
      KIND_PROBE = 2'd0,
      KIND_ECHO  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [15:0]        probes;
      logic [15:0]        echoes;
      logic [15:0]        samples;
      logic signed [31:0] rssi_sum;
      logic signed [11:0] rssi_min;
      logic signed [11:0] rssi_max;
      logic signed [31:0] snr_sum;
      logic signed [11:0] snr_min;
      logic signed [11:0] snr_max;
   } stats_type;

   // Command broadcast to every cell for one event.
   typedef struct packed {
      logic               lookup;
      logic               update;
      logic               clear;
      logic               take;
      logic [IdxW-1:0]    target;
      kind_type           kind;
      logic [15:0]        position;
      logic signed [11:0] rssi;
      logic signed [11:0] snr;
   } cmd_type;

   // Travels down the chain: first match found so far and its data.
   typedef struct packed {
      logic            hit;
      logic [IdxW-1:0] index;
      stats_type       stats;
   } link_type;
endpackage
`default_nettype wire

### hdl/pst_cell.sv
`default_nettype none
module pst_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [pst_pkg::IdxW-1:0] my_index,
   input  wire pst_pkg::cmd_type  cmd,
   input  wire pst_pkg::link_type link_in,
   output pst_pkg::link_type      link_out,
   output pst_pkg::stats_type     stats
);
   import pst_pkg::*;

   logic        valid_ff, valid_in;
   logic [15:0] pos_ff;
   stats_type   stats_ff, stats_in;
   logic        match;

   assign match = valid_ff && (pos_ff == cmd.position);
   assign stats = stats_ff;

   always_comb begin
      link_out = link_in;
      if (!link_in.hit && match) begin
         link_out.hit   = 1'b1;
         link_out.index = my_index;
         link_out.stats = stats_ff;
      end
   end

   always_comb begin
      stats_type b;
      valid_in = valid_ff;
      b = stats_ff;
      if (cmd.take) b = '0;
      stats_in = b;
      if (cmd.clear) valid_in = 1'b0;
      else if (cmd.update && cmd.target == my_index) begin
         valid_in = 1'b1;
         if (cmd.kind == KIND_PROBE) begin
            stats_in.probes  = b.probes + 16'd1;
            stats_in.samples = b.samples + 16'd1;
            stats_in.rssi_sum = b.rssi_sum + 32'(cmd.rssi);
            stats_in.snr_sum  = b.snr_sum + 32'(cmd.snr);
            if (b.samples == 16'd0) begin
               stats_in.rssi_min = cmd.rssi; stats_in.rssi_max = cmd.rssi;
               stats_in.snr_min  = cmd.snr;  stats_in.snr_max  = cmd.snr;
            end else begin
               if (cmd.rssi < b.rssi_min) stats_in.rssi_min = cmd.rssi;
               if (cmd.rssi > b.rssi_max) stats_in.rssi_max = cmd.rssi;
               if (cmd.snr < b.snr_min) stats_in.snr_min = cmd.snr;
               if (cmd.snr > b.snr_max) stats_in.snr_max = cmd.snr;
            end
         end else begin
            stats_in.echoes = b.echoes + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (cmd.update && cmd.target == my_index) begin
         stats_ff <= stats_in;
         pos_ff   <= cmd.position;
      end
   end
endmodule
`default_nettype wire

### hdl/position_stats_table.sv
// A probe or echo result is offered after its request beat passes the lookup stage and the
// cell update, registered in out_ff; a clear or unused-kind result skips the cell update.
// One event at a time: no new request beat is accepted until the last result has been
// taken, so every cycle rsp_tready is low holds the next beat off.
// Reset (synchronous, active high) empties the table, clears the fill level,
// ring pointer and overflow flag, and leaves no result pending.
`default_nettype none
`include "position_stats_table_defines.svh"
module position_stats_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // position[15:0], rssi[27:16], snr[39:28]
   input  wire logic [1:0]  req_tuser,  // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [167:0]     rsp_tdata,  // slot, new_entry, overflowed, heard_count,
                                        // echo_count, sample_count, rssi_total, rssi_low,
                                        // rssi_high, snr_total, snr_low, snr_high, pad
   output logic [0:0]       rsp_tuser   // unused marker, always zero
);
   import pst_pkg::*;

   // busy_ff marks an event held in the lookup stage; out_ff the result beat.
   logic              busy_ff, busy_in;
   logic              out_ff, out_in;
   kind_type          kind_ff;
   logic [15:0]       pos_ff;
   logic signed [11:0] rssi_ff, snr_ff;
   logic [FillW-1:0]  fill_ff, fill_in;
   logic [IdxW-1:0]   ptr_ff, ptr_in;
   logic              ovf_ff, ovf_in;
   logic [IdxW-1:0]   slot_ff;
   logic              fresh_ff, fresh_in;
   logic              upd_ff;
   logic [167:0]      data_ff, data_in;
   logic              overwrite;

   cmd_type   cmd;
   link_type  chain [Capacity+1];
   stats_type cell_stats [Capacity];
   logic [IdxW-1:0] target;

   // Hand the cells a zero link at the head; each passes on the first match.
   assign chain[0] = '0;

   for (genvar g = 0; g < Capacity; g++) begin : g_cell
      pst_cell u_cell (
         .clock(clock), .reset(reset), .my_index(IdxW'(g)), .cmd(cmd),
         .link_in(chain[g]), .link_out(chain[g+1]), .stats(cell_stats[g]));
   end

   assign req_tready = !busy_ff && !upd_ff && !out_ff;
   assign rsp_tvalid = out_ff;
   assign rsp_tuser  = 1'b0;

   // The lookup stage decides the target and issues the write to the cells.
   always_comb begin
      logic work;
      work = busy_ff && (kind_ff == KIND_PROBE || kind_ff == KIND_ECHO);
      fill_in  = fill_ff;
      ptr_in   = ptr_ff;
      ovf_in   = ovf_ff;
      fresh_in = 1'b0;
      target   = chain[Capacity].index;
      if (work && !chain[Capacity].hit) begin
         fresh_in = 1'b1;
         if (fill_ff < FillW'(Capacity)) begin
            target  = fill_ff[IdxW-1:0];
            fill_in = fill_ff + 1'b1;
            ptr_in  = (fill_ff + 1'b1 == FillW'(Capacity)) ? '0 : IdxW'(fill_ff + 1'b1);
         end else begin
            target = ptr_ff;
            ptr_in = (ptr_ff == IdxW'(Capacity - 1)) ? '0 : ptr_ff + 1'b1;
            ovf_in = 1'b1;
         end
      end
      if (busy_ff && kind_ff == KIND_CLEAR) begin
         fill_in = '0; ptr_in = '0; ovf_in = 1'b0;
      end
      cmd.lookup   = busy_ff;
      cmd.update   = work;
      cmd.clear    = busy_ff && kind_ff == KIND_CLEAR;
      cmd.take     = fresh_in;
      cmd.target   = target;
      cmd.kind     = kind_ff;
      cmd.position = pos_ff;
      cmd.rssi     = rssi_ff;
      cmd.snr      = snr_ff;
   end

   // The result is read from the updated cell in the cycle after the write.
   always_comb begin
      stats_type s;
      s = cell_stats[slot_ff];
      data_in = data_ff;
      if (upd_ff) begin
         data_in = {1'b0, s.snr_max, s.snr_min, s.snr_sum, s.rssi_max, s.rssi_min,
                    s.rssi_sum, s.samples, s.echoes, s.probes, ovf_ff, fresh_ff,
                    5'(slot_ff)};
      end else if (busy_ff && (kind_ff == KIND_CLEAR || kind_ff == KIND_NONE)) begin
         data_in = '0;
         data_in[6] = (kind_ff == KIND_NONE) ? ovf_ff : 1'b0;
      end
      out_in  = out_ff;
      if (out_ff && rsp_tready) out_in = 1'b0;
      if (upd_ff || (busy_ff && (kind_ff == KIND_CLEAR || kind_ff == KIND_NONE)))
         out_in = 1'b1;
      busy_in = req_tvalid && req_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upd_ff  <= 1'b0;
         out_ff  <= 1'b0;
         fill_ff <= '0;
         ptr_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         upd_ff  <= cmd.update;
         out_ff  <= out_in;
         fill_ff <= fill_in;
         ptr_ff  <= ptr_in;
         ovf_ff  <= ovf_in;
      end
      if (req_tvalid && req_tready) begin
         kind_ff <= kind_type'(req_tuser);
         pos_ff  <= req_tdata[15:0];
         rssi_ff <= req_tdata[27:16];
         snr_ff  <= req_tdata[39:28];
      end
      slot_ff  <= target;
      fresh_ff <= fresh_in;
      data_ff  <= data_in;
   end

   assign rsp_tdata = data_ff;
   assign overwrite = cmd.update && fresh_in && fill_ff == FillW'(Capacity);

   `PST_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FillW'(Capacity), "fill overrun")
   `PST_ASSERT_IMP(a_one_stage, clock, reset, busy_ff, !upd_ff && !out_ff, "overlapping events")
   `PST_ASSERT_NEXT(a_ovf_full, clock, reset, overwrite, ovf_ff, "overwrite without overflow")
endmodule
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pst_pkg::*;

   localparam int CycleLimit = 400000;

   // One expected beat of the result channel, split into its fields.
   typedef struct packed {
      logic [4:0] slot;
      logic       new_entry;
      logic       overflowed;
      stats_type  stats;
   } entry_report_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [39:0]  req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [167:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   position_stats_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow copy of the table, advanced once per accepted request beat.
   logic        shadow_valid [Capacity];
   logic [15:0] shadow_position [Capacity];
   stats_type   shadow_stats [Capacity];
   int          shadow_fill;
   int          shadow_ring;
   logic        shadow_overflow;

   entry_report_type pending_reports [$];
   int  error_count;
   int  cycle_count;
   int  burst_left;
   int  probes_sent, echo_beats, clears_sent, unused_sent, overwrites_seen;
   int  reports_checked;

   function automatic void wipe_shadow();
      for (int i = 0; i < Capacity; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_position[i] = '0;
         shadow_stats[i] = '0;
      end
      shadow_fill = 0;
      shadow_ring = 0;
      shadow_overflow = 1'b0;
   endfunction

   // Works out the report for one event and updates the shadow table.
   function automatic entry_report_type apply_event(kind_type k, logic [15:0] pos,
                                                    logic signed [11:0] rssi,
                                                    logic signed [11:0] snr);
      entry_report_type rep;
      int idx;
      logic fresh;
      rep = '0;
      idx = -1;
      fresh = 1'b0;
      if (k == KIND_CLEAR) begin
         wipe_shadow();
         return rep;
      end
      if (k == KIND_NONE) begin
         rep.overflowed = shadow_overflow;
         return rep;
      end
      for (int i = 0; i < shadow_fill; i++)
         if (idx < 0 && shadow_valid[i] && shadow_position[i] == pos) idx = i;
      if (idx < 0) begin
         fresh = 1'b1;
         if (shadow_fill < Capacity) begin
            idx = shadow_fill;
            shadow_fill++;
            shadow_ring = shadow_fill % Capacity;
         end else begin
            idx = shadow_ring;
            shadow_ring = (shadow_ring + 1) % Capacity;
            shadow_overflow = 1'b1;
            overwrites_seen++;
         end
         shadow_stats[idx] = '0;
         shadow_position[idx] = pos;
         shadow_valid[idx] = 1'b1;
      end
      if (k == KIND_PROBE) begin
         shadow_stats[idx].probes = shadow_stats[idx].probes + 16'd1;
         // The first sample of an entry seeds both extremes.
         if (shadow_stats[idx].samples == 16'd0) begin
            shadow_stats[idx].rssi_min = rssi;
            shadow_stats[idx].rssi_max = rssi;
            shadow_stats[idx].snr_min = snr;
            shadow_stats[idx].snr_max = snr;
         end else begin
            if (rssi < shadow_stats[idx].rssi_min) shadow_stats[idx].rssi_min = rssi;
            if (rssi > shadow_stats[idx].rssi_max) shadow_stats[idx].rssi_max = rssi;
            if (snr < shadow_stats[idx].snr_min) shadow_stats[idx].snr_min = snr;
            if (snr > shadow_stats[idx].snr_max) shadow_stats[idx].snr_max = snr;
         end
         shadow_stats[idx].rssi_sum = shadow_stats[idx].rssi_sum + 32'(rssi);
         shadow_stats[idx].snr_sum = shadow_stats[idx].snr_sum + 32'(snr);
         shadow_stats[idx].samples = shadow_stats[idx].samples + 16'd1;
      end else begin
         shadow_stats[idx].echoes = shadow_stats[idx].echoes + 16'd1;
      end
      rep.slot = idx[4:0];
      rep.new_entry = fresh;
      rep.overflowed = shadow_overflow;
      rep.stats = shadow_stats[idx];
      return rep;
   endfunction

   // Sends one event beat; the sender runs in bursts with random gaps between them.
   task automatic send_event(kind_type k, logic [15:0] pos,
                             logic signed [11:0] rssi, logic signed [11:0] snr);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= {snr, rssi, pos};
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(apply_event(k, pos, rssi, snr));
      case (k)
         KIND_PROBE: probes_sent++;
         KIND_ECHO:  echo_beats++;
         KIND_CLEAR: clears_sent++;
         default:    unused_sent++;
      endcase
   endtask

   // Holds the sender off until every outstanding report has been checked.
   task automatic drain_reports();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      wait (pending_reports.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // Result checker: each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      entry_report_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t ns: result beat with nothing expected, got %h", $time, rsp_tdata);
            error_count++;
         end else begin
            exp_r = pending_reports.pop_front();
            reports_checked++;
            compare_field("slot", 32'(exp_r.slot), 32'(rsp_tdata[4:0]));
            compare_field("new_entry", 32'(exp_r.new_entry), 32'(rsp_tdata[5]));
            compare_field("overflowed", 32'(exp_r.overflowed), 32'(rsp_tdata[6]));
            compare_field("heard_count", 32'(exp_r.stats.probes), 32'(rsp_tdata[22:7]));
            compare_field("echo_count", 32'(exp_r.stats.echoes), 32'(rsp_tdata[38:23]));
            compare_field("sample_count", 32'(exp_r.stats.samples), 32'(rsp_tdata[54:39]));
            compare_field("rssi_total", exp_r.stats.rssi_sum, rsp_tdata[86:55]);
            compare_field("rssi_low", 32'(unsigned'(exp_r.stats.rssi_min)),
                          32'(rsp_tdata[98:87]));
            compare_field("rssi_high", 32'(unsigned'(exp_r.stats.rssi_max)),
                          32'(rsp_tdata[110:99]));
            compare_field("snr_total", exp_r.stats.snr_sum, rsp_tdata[142:111]);
            compare_field("snr_low", 32'(unsigned'(exp_r.stats.snr_min)),
                          32'(rsp_tdata[154:143]));
            compare_field("snr_high", 32'(unsigned'(exp_r.stats.snr_max)),
                          32'(rsp_tdata[166:155]));
         end
      end
   end

   // Receiver back-pressure: its own pattern of free running, random and long stalls.
   int stall_left;
   int stall_mode;
   int mode_left;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left <= $urandom_range(20, 120);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_mode == 0) begin
         rsp_tready <= 1'b1;
      end else if (stall_mode == 1) begin
         rsp_tready <= ($urandom_range(0, 9) < 7);
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 15);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_reports.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Extremes of every field on the first entries of an empty table.
   task automatic test_probe_extremes();
      send_event(KIND_PROBE, 16'h0000, -12'sd2048, 12'sd2047);
      send_event(KIND_PROBE, 16'h0000, 12'sd2047, -12'sd2048);
      send_event(KIND_PROBE, 16'hFFFF, 12'sd2047, 12'sd2047);
      send_event(KIND_PROBE, 16'hFFFF, -12'sd2048, -12'sd2048);
      send_event(KIND_PROBE, 16'hFFFF, 12'sd0, -12'sd1);
   endtask

   // Echo ignores the sample fields; a first probe after echoes still seeds the extremes.
   task automatic test_echo_then_first_sample();
      send_event(KIND_ECHO, 16'hA5A5, 12'sd2047, -12'sd2048);
      send_event(KIND_ECHO, 16'hA5A5, -12'sd1, 12'sd1);
      send_event(KIND_PROBE, 16'hA5A5, -12'sd300, 12'sd85);
      send_event(KIND_ECHO, 16'h0000, 12'sd0, 12'sd0);
   endtask

   // Unused kind reports only the flag; clear empties the table and resets the flag.
   task automatic test_unused_and_clear();
      send_event(KIND_NONE, 16'h5A5A, -12'sd7, 12'sd7);
      send_event(KIND_CLEAR, 16'h1234, 12'sd5, 12'sd5);
      send_event(KIND_NONE, 16'h0000, 12'sd0, 12'sd0);
      send_event(KIND_ECHO, 16'hFFFF, 12'sd0, 12'sd0);
      send_event(KIND_PROBE, 16'h0000, 12'sd1, -12'sd1);
      send_event(KIND_CLEAR, 16'h0000, 12'sd0, 12'sd0);
   endtask

   // Random traffic over position pools of varied size, so the table both
   // hits repeatedly and overflows into its ring replacement.
   task automatic test_random_traffic(int count);
      int pool;
      int phase_left;
      int pick;
      logic [15:0] base;
      logic [15:0] pos;
      logic signed [11:0] rssi;
      logic signed [11:0] snr;
      kind_type k;
      phase_left = 0;
      pool = 1;
      base = '0;
      for (int n = 0; n < count; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(40, 160);
            case ($urandom_range(0, 3))
               0: pool = $urandom_range(1, 6);
               1: pool = $urandom_range(10, 32);
               2: pool = $urandom_range(33, 48);
               default: pool = 65536;
            endcase
            base = 16'($urandom_range(0, 65535));
         end
         phase_left--;
         if (n == count / 2) drain_reports();
         pos = (pool == 65536) ? 16'($urandom_range(0, 65535))
                               : base + 16'($urandom_range(0, pool - 1));
         pick = $urandom_range(0, 99);
         if (pick < 60) k = KIND_PROBE;
         else if (pick < 94) k = KIND_ECHO;
         else if (pick < 97) k = KIND_NONE;
         else k = KIND_CLEAR;
         if ($urandom_range(0, 4) == 0) begin
            rssi = $urandom_range(0, 1) ? 12'sh800 : 12'sh7FF;
            snr = $urandom_range(0, 1) ? 12'sh800 : 12'sh7FF;
         end else begin
            rssi = 12'($urandom_range(0, 4095));
            snr = 12'($urandom_range(0, 4095));
         end
         send_event(k, pos, rssi, snr);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_PROBE;
      rsp_tready = 1'b0;
      error_count = 0;
      cycle_count = 0;
      burst_left = 0;
      stall_left = 0;
      stall_mode = 0;
      mode_left = 0;
      reports_checked = 0;
      wipe_shadow();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_probe_extremes();
      test_echo_then_first_sample();
      test_unused_and_clear();
      test_random_traffic(850);

      drain_reports();
      repeat (8) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $display("%0d expected results never arrived", pending_reports.size());
         error_count++;
      end
      $display("covered %0d probes, %0d echoes, %0d clears, %0d unused-kind beats",
               probes_sent, echo_beats, clears_sent, unused_sent);
      $display("%0d ring overwrites, %0d result beats compared, %0d mismatches",
               overwrites_seen, reports_checked, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire
